>>> rtl/core/spiadc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI ADC reader package
// Shared constants, widths and the packed result type of the SPI ADC reader.
// ----------------------------------------------------------------------------
package spiadc_pkg;

    // frame layout
    localparam int FRAME_BITS   = 20;
    localparam int CAPTURE_BITS = 13;
    localparam int COMMAND_BITS = 5;

    // widths of the internal state
    localparam int BIT_IDX_W  = 5;
    localparam int DIV_W      = 10;
    localparam int HALF_W     = 11;
    localparam int CMD_IDX_W  = 3;

    // serial clock phase length limits
    localparam logic [HALF_W-1:0] HALF_MIN = HALF_W'(1);
    localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(1024);

    // first frame bit that goes into the capture register
    localparam logic [BIT_IDX_W-1:0] CAPTURE_FIRST = BIT_IDX_W'(FRAME_BITS - CAPTURE_BITS);
    localparam logic [BIT_IDX_W:0]   FRAME_LEN     = (BIT_IDX_W + 1)'(FRAME_BITS);
    localparam logic [BIT_IDX_W-1:0] CMD_LEN       = BIT_IDX_W'(COMMAND_BITS);
    localparam logic [CMD_IDX_W-1:0] CMD_TOP       = CMD_IDX_W'(COMMAND_BITS - 1);

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // result transaction, lowest field in the lowest bit
    typedef struct packed {
        logic [5:0]                    pad;
        logic signed [CAPTURE_BITS-1:0] conversion_value;
        logic                          done_res;
        logic                          busy_res;
        logic                          mosi_level;
        logic                          serial_clock;
        logic                          chip_select_n;
    } result_t;

endpackage

>>> rtl/core/spi_adc_conversion_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI ADC conversion reader
// SPI master that reads one conversion from a multichannel ADC, stepped by
// one tick per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_ stream is one tick of pin timing. It carries a
//   start request, the channel, the differential flag and the sampled MISO
//   level. Each tick produces exactly one transaction on the m_ stream with
//   the pin levels to drive (chip select, serial clock, MOSI), busy and done
//   flags and, on the done tick, the 13-bit conversion value.
//   cfg_we/cfg_wdata set the ticks per clock phase (0 acts as 1, values
//   above 1024 act as 1024); write it only while the reader is idle.
//   An accepted tick shows up in the result register on the next clock.
//   Throughput is one tick per cycle while the receiver takes each result,
//   set by the single result register that holds the step logic output.
//   When the receiver stalls, the result register holds and s_tready drops
//   until the result is taken; no tick is lost or repeated.
//   Reset clears the frame state to idle, empties the result register and
//   sets the phase length to one tick.
// ----------------------------------------------------------------------------
module spi_adc_conversion_reader
    import spiadc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // ticks per clock phase
    input  logic                  cfg_we,
    input  logic [HALF_W-1:0]     cfg_wdata,
    // start_req, channel[2:0], differential, miso_level, zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // chip_select_n, serial_clock, mosi_level, busy_res, done_res,
    // conversion_value[12:0], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // configuration and frame state
    logic [HALF_W-1:0]       half_reg;
    logic                    active_reg,   active_next;
    logic [BIT_IDX_W-1:0]    bit_idx_reg,  bit_idx_next;
    logic                    phase_reg,    phase_next;
    logic [DIV_W-1:0]        div_reg,      div_next;
    logic [COMMAND_BITS-1:0] cmd_reg,      cmd_next;
    logic [CAPTURE_BITS-1:0] cap_reg,      cap_next;
    logic                    signed_reg,   signed_next;

    // result register
    logic                    out_valid_reg;
    result_t                 out_reg,      out_next;

    // input fields
    logic                    start_req;
    logic [2:0]              channel;
    logic                    differential;
    logic                    miso_level;
    logic                    accept;

    // working values of the current tick
    logic                    starting;
    logic [BIT_IDX_W-1:0]    cur_idx;
    logic                    cur_phase;
    logic [DIV_W-1:0]        cur_div;
    logic [COMMAND_BITS-1:0] cur_cmd;
    logic [CAPTURE_BITS-1:0] cur_cap;
    logic                    cur_signed;
    logic [HALF_W-1:0]       phase_len;
    logic [DIV_W-1:0]        div_inc;
    logic                    phase_end;
    logic [BIT_IDX_W-1:0]    idx_inc;
    logic                    frame_end;
    logic                    mosi_bit;
    logic [CMD_IDX_W-1:0]    cmd_sel;

    assign start_req    = s_tdata[0];
    assign channel      = s_tdata[3:1];
    assign differential = s_tdata[4];
    assign miso_level   = s_tdata[5];

    // handshake: take a tick whenever the result register is free or drains
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // phase length with zero and overrange clamped
    always_comb
    begin
        if (half_reg == '0)
            phase_len = HALF_MIN;
        else if (half_reg > HALF_MAX)
            phase_len = HALF_MAX;
        else
            phase_len = half_reg;
    end

    // state seen by this tick: a start while idle begins a fresh frame
    always_comb
    begin
        starting = !active_reg && start_req;
        if (starting)
        begin
            cur_idx    = '0;
            cur_phase  = 1'b0;
            cur_div    = '0;
            cur_cap    = '0;
            cur_signed = differential;
            cur_cmd    = {1'b1, !differential, channel};
        end
        else
        begin
            cur_idx    = bit_idx_reg;
            cur_phase  = phase_reg;
            cur_div    = div_reg;
            cur_cap    = cap_reg;
            cur_signed = signed_reg;
            cur_cmd    = cmd_reg;
        end
    end

    // command bit on mosi, first bit most significant
    always_comb
    begin
        cmd_sel  = CMD_TOP - cur_idx[CMD_IDX_W-1:0];
        mosi_bit = (cur_idx < CMD_LEN) ? cur_cmd[cmd_sel] : 1'b0;
    end

    // divider and bit counter steps
    always_comb
    begin
        div_inc   = cur_div + DIV_W'(1);
        phase_end = (div_inc == '0) || ({1'b0, div_inc} >= phase_len);
        idx_inc   = cur_idx + BIT_IDX_W'(1);
        frame_end = phase_end && cur_phase &&
                    ((idx_inc == '0) || ({1'b0, idx_inc} >= FRAME_LEN));
    end

    // next frame state and result of this tick
    always_comb
    begin
        active_next = active_reg;
        bit_idx_next = bit_idx_reg;
        phase_next  = phase_reg;
        div_next    = div_reg;
        cmd_next    = cmd_reg;
        cap_next    = cap_reg;
        signed_next = signed_reg;

        out_next                  = '0;
        out_next.chip_select_n    = 1'b1;

        if (active_reg || start_req)
        begin
            cmd_next    = cur_cmd;
            signed_next = cur_signed;

            out_next.chip_select_n = 1'b0;
            out_next.serial_clock  = cur_phase;
            out_next.mosi_level    = mosi_bit;
            out_next.busy_res      = 1'b1;

            // sample miso on the first tick of a high phase, from the first capture bit on
            if (cur_phase && (cur_div == '0) && (cur_idx >= CAPTURE_FIRST))
                cap_next = {cur_cap[CAPTURE_BITS-2:0], miso_level};
            else
                cap_next = cur_cap;

            if (phase_end)
            begin
                div_next   = '0;
                phase_next = !cur_phase;
                bit_idx_next = cur_phase ? idx_inc : cur_idx;
            end
            else
            begin
                div_next     = div_inc;
                phase_next   = cur_phase;
                bit_idx_next = cur_idx;
            end

            active_next = 1'b1;
            if (frame_end)
            begin
                bit_idx_next      = '0;
                active_next       = 1'b0;
                out_next.done_res = 1'b1;
                out_next.conversion_value = cur_signed ? cap_next
                                                       : {1'b0, cap_next[CAPTURE_BITS-2:0]};
            end
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= HALF_MIN;
        else if (cfg_we)
            half_reg <= cfg_wdata;
    end

    // frame state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            bit_idx_reg <= '0;
            phase_reg   <= 1'b0;
            div_reg     <= '0;
            cmd_reg     <= '0;
            cap_reg     <= '0;
            signed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            active_reg  <= active_next;
            bit_idx_reg <= bit_idx_next;
            phase_reg   <= phase_next;
            div_reg     <= div_next;
            cmd_reg     <= cmd_next;
            cap_reg     <= cap_next;
            signed_reg  <= signed_next;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    // idle leaves the counters parked at the start of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bit_idx_reg == '0) && !phase_reg && (div_reg == '0))
        else $error("idle with frame counters not parked");

    // chip select and busy are complementary in every result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.chip_select_n == !out_reg.busy_res))
        else $error("chip select and busy disagree");

    // a value is reported only on the done tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |-> (out_reg.conversion_value == '0))
        else $error("conversion value outside done tick");

    // a done tick ends the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_next.done_res) |=> !active_reg)
        else $error("frame still active after done");

    // the frame only starts from a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !active_reg && !start_req) |=> !active_reg)
        else $error("frame started without request");

endmodule
